### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the rtl; compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// condition that implies a consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindErr  = 2'd2;

  // error codes
  localparam logic [2:0] ErrNone         = 3'd0;
  localparam logic [2:0] ErrExpectQuote  = 3'd1;
  localparam logic [2:0] ErrBadEscape    = 3'd2;
  localparam logic [2:0] ErrBadHex       = 3'd3;
  localparam logic [2:0] ErrUnterminated = 3'd4;
  localparam logic [2:0] ErrEscapeAtEnd  = 3'd5;
  localparam logic [2:0] ErrHexShort     = 3'd6;

  // input command
  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // characters of interest
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0c;

  // utf-8 limits and marks
  localparam logic [15:0] Utf8Max1 = 16'h007f;
  localparam logic [15:0] Utf8Max2 = 16'h07ff;
  localparam logic [7:0]  Utf8Lead2 = 8'hc0;
  localparam logic [7:0]  Utf8Lead3 = 8'he0;
  localparam logic [7:0]  Utf8Cont  = 8'h80;

  // result queue
  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoAw     = 3;
  localparam int unsigned FifoDepth  = 2 ** FifoAw;
  localparam logic [FifoAw:0] FifoRoomLimit = (FifoAw + 1)'(FifoDepth - MaxResults);
  localparam logic [FifoAw:0] FifoFull      = (FifoAw + 1)'(FifoDepth);

  // one result word
  typedef struct packed {
    logic       last;
    logic [2:0] err;
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

endpackage

### rtl/json_string_unescaper_core.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Decodes a json string literal from a byte stream into utf-8 bytes
// ----------------------------------------------------------------------------
// Each input word is taken into an input register and decoded from there,
// once the queue has room, into up to three result words, which go into an
// eight-entry result queue. A new word is taken every cycle while the queue
// has room for three more results, so plain bytes run at one word per cycle
// and pass through the input register and the result queue; across a \u
// escape the six input words give up to three results; the queue drains
// one result per cycle, which sets the sustained rate when the output is busy.
`include "assert_macros.svh"

module json_string_unescaper_core
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] command
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  typedef enum logic [1:0] {
    PhSeek,
    PhBody,
    PhEsc,
    PhHex
  } phase_e;

  // input register
  logic       in_valid_q, in_valid_d;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  // decoder state
  phase_e      phase_q, phase_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;
  logic [15:0] cp_q, cp_d;
  logic        bad_q, bad_d;

  // result queue
  result_t           fifo_q [FifoDepth];
  logic [FifoAw-1:0] wr_q, wr_d;
  logic [FifoAw-1:0] rd_q, rd_d;
  logic [FifoAw:0]   cnt_q, cnt_d;

  logic    proc;
  logic    pop;
  logic    accept;
  result_t res [MaxResults];
  logic [1:0] n_res;
  logic [1:0] n_push;

  // hex digit decode
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [15:0] cp_next;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_q >= 8'h30 && in_byte_q <= 8'h39) begin
      hex_val = 4'(in_byte_q - 8'h30);
    end else if (in_byte_q >= 8'h61 && in_byte_q <= 8'h66) begin
      hex_val = 4'(in_byte_q - 8'h57);
    end else if (in_byte_q >= 8'h41 && in_byte_q <= 8'h46) begin
      hex_val = 4'(in_byte_q - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    cp_next = {cp_q[11:0], hex_val};
  end

  // handshake and queue room
  assign proc          = in_valid_q && (cnt_q <= FifoRoomLimit);
  assign s_axis_tready = !in_valid_q || proc;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;

  // decode one word into results and next state
  always_comb begin
    logic [7:0] esc_byte;
    logic       esc_ok;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '0;
    end
    n_res     = 2'd0;
    phase_d   = phase_q;
    hex_cnt_d = hex_cnt_q;
    cp_d      = cp_q;
    bad_d     = bad_q;
    esc_byte  = 8'h00;
    esc_ok    = 1'b1;

    if (in_cmd_q == CmdEnd) begin
      res[0].kind = KindErr;
      unique case (phase_q)
        PhBody:  res[0].err = ErrUnterminated;
        PhEsc:   res[0].err = ErrEscapeAtEnd;
        PhHex:   res[0].err = ErrHexShort;
        default: res[0].err = ErrExpectQuote;
      endcase
      n_res = 2'd1;
    end else begin
      unique case (phase_q)
        PhSeek: begin
          if (in_byte_q == ChQuote) begin
            phase_d = PhBody;
          end else if (!(in_byte_q == ChSpace || in_byte_q == ChTab ||
                         in_byte_q == ChCr || in_byte_q == ChLf)) begin
            res[0].kind = KindErr;
            res[0].err  = ErrExpectQuote;
            n_res       = 2'd1;
          end
        end
        PhBody: begin
          if (in_byte_q == ChQuote) begin
            res[0].kind = KindDone;
            n_res       = 2'd1;
            phase_d     = PhSeek;
          end else if (in_byte_q == ChBslash) begin
            phase_d = PhEsc;
          end else begin
            res[0].kind = KindByte;
            res[0].data = in_byte_q;
            n_res       = 2'd1;
          end
        end
        PhEsc: begin
          case (in_byte_q)
            ChQuote:  esc_byte = ChQuote;
            ChBslash: esc_byte = ChBslash;
            ChSlash:  esc_byte = ChSlash;
            ChB:      esc_byte = ChBs;
            ChF:      esc_byte = ChFf;
            ChN:      esc_byte = ChLf;
            ChR:      esc_byte = ChCr;
            ChT:      esc_byte = ChTab;
            default:  esc_ok   = 1'b0;
          endcase
          if (in_byte_q == ChU) begin
            phase_d   = PhHex;
            hex_cnt_d = 2'd0;
            cp_d      = '0;
            bad_d     = 1'b0;
          end else if (esc_ok) begin
            res[0].kind = KindByte;
            res[0].data = esc_byte;
            n_res       = 2'd1;
            phase_d     = PhBody;
          end else begin
            res[0].kind = KindErr;
            res[0].err  = ErrBadEscape;
            n_res       = 2'd1;
          end
        end
        PhHex: begin
          cp_d  = cp_next;
          bad_d = bad_q || !is_hex;
          if (hex_cnt_q != 2'd3) begin
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else if (bad_d) begin
            res[0].kind = KindErr;
            res[0].err  = ErrBadHex;
            n_res       = 2'd1;
          end else begin
            // utf-8 encoding of the gathered code point
            phase_d   = PhBody;
            hex_cnt_d = 2'd0;
            cp_d      = '0;
            if (cp_next <= Utf8Max1) begin
              res[0].data = cp_next[7:0];
              n_res       = 2'd1;
            end else if (cp_next <= Utf8Max2) begin
              res[0].data = Utf8Lead2 | {3'b000, cp_next[10:6]};
              res[1].data = Utf8Cont | {2'b00, cp_next[5:0]};
              n_res       = 2'd2;
            end else begin
              res[0].data = Utf8Lead3 | {4'b0000, cp_next[15:12]};
              res[1].data = Utf8Cont | {2'b00, cp_next[11:6]};
              res[2].data = Utf8Cont | {2'b00, cp_next[5:0]};
              n_res       = 2'd3;
            end
          end
        end
        default: phase_d = PhSeek;
      endcase
    end

    // done and errors send the decoder back to seeking
    if (res[0].kind != KindByte) begin
      phase_d   = PhSeek;
      hex_cnt_d = 2'd0;
      cp_d      = '0;
      bad_d     = 1'b0;
    end

    // mark the final result of the word
    for (int i = 0; i < MaxResults; i++) begin
      res[i].last = (2'(i) == n_res - 2'd1) && (n_res != 2'd0);
    end
  end

  // queue pointers and input register next values
  always_comb begin
    n_push     = proc ? n_res : 2'd0;
    wr_d       = wr_q + FifoAw'(n_push);
    rd_d       = rd_q + FifoAw'(pop);
    cnt_d      = cnt_q + (FifoAw + 1)'(n_push) - (FifoAw + 1)'(pop);
    in_valid_d = accept ? 1'b1 : (proc ? 1'b0 : in_valid_q);
  end

  // state, input register and result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PhSeek;
      hex_cnt_q  <= 2'd0;
      cp_q       <= '0;
      bad_q      <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      wr_q       <= wr_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
      if (proc) begin
        phase_q   <= phase_d;
        hex_cnt_q <= hex_cnt_d;
        cp_q      <= cp_d;
        bad_q     <= bad_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_cmd_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < n_push) begin
        fifo_q[wr_q + FifoAw'(i)] <= res[i];
      end
    end
  end

  // result stream
  assign m_axis_tdata = {5'b00000, fifo_q[rd_q].err, fifo_q[rd_q].data};
  assign m_axis_tuser = fifo_q[rd_q].kind;
  assign m_axis_tlast = fifo_q[rd_q].last;

  // assertions
  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= FifoFull)
  `ASSERT_IMPLY(a_room_on_proc, clk_i, rst_ni, in_valid_q && s_axis_tready,
                cnt_q <= FifoRoomLimit)
  `ASSERT_IMPLY(a_hex_idle, clk_i, rst_ni, phase_q != PhHex,
                hex_cnt_q == 2'd0 && !bad_q)
  `ASSERT_IMPLY(a_end_is_last, clk_i, rst_ni,
                m_axis_tvalid && m_axis_tuser != KindByte, m_axis_tlast)

endmodule

### verif/tb_json_string_unescaper_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_core
// Self-checking bench for the json string unescaper core
// ----------------------------------------------------------------------------
// Byte words and end-of-input marks go in on the slave stream; a scoreboard
// keeps its own decoder state and queues the words each input should give.
// Every word leaving the master stream is matched against the oldest queued
// word. Stimulus is a short directed sequence, then mostly well-formed
// strings with random content (plain bytes, escapes, \u code points of one to
// three utf-8 bytes) mixed with broken strings and noise, under random bursts,
// gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_json_string_unescaper_core;
  import jsu_pkg::*;

  localparam int unsigned NumRandomWords = 280;
  localparam int unsigned FlushCycles    = 20;
  localparam realtime     RunLimit       = 5ms;

  // digits for \u escapes
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChHexLow = 8'h61;
  localparam logic [7:0] ChHexUp  = 8'h41;

  // decoder model and queue of words still to come out
  class unescape_board;
    typedef enum logic [2:0] {ScanSeek, ScanBody, ScanEscape, ScanHex} scan_e;

    scan_e       scan;
    logic [1:0]  digits;
    logic [15:0] code_point;
    logic        bad_digit;
    result_t     pending_words[$];
    result_t     run_words[$];
    int          mismatches;
    int          words_checked;
    int          strings_closed;
    int          errors_reported;

    function new();
      clear_scan();
      mismatches      = 0;
      words_checked   = 0;
      strings_closed  = 0;
      errors_reported = 0;
    endfunction

    static function int hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function void clear_scan();
      scan       = ScanSeek;
      digits     = 2'd0;
      code_point = 16'h0000;
      bad_digit  = 1'b0;
    endfunction

    function void put(logic [7:0] d, logic [1:0] k, logic [2:0] e);
      result_t w;
      w.data = d;
      w.kind = k;
      w.err  = e;
      w.last = 1'b0;
      run_words = {run_words, w};
    endfunction

    function void fail(logic [2:0] e);
      clear_scan();
      put(8'h00, KindErr, e);
    endfunction

    function void put_utf8(logic [15:0] cp);
      if (cp <= Utf8Max1) begin
        put(cp[7:0], KindByte, ErrNone);
      end else if (cp <= Utf8Max2) begin
        put(Utf8Lead2 | {3'b000, cp[10:6]}, KindByte, ErrNone);
        put(Utf8Cont | {2'b00, cp[5:0]}, KindByte, ErrNone);
      end else begin
        put(Utf8Lead3 | {4'b0000, cp[15:12]}, KindByte, ErrNone);
        put(Utf8Cont | {2'b00, cp[11:6]}, KindByte, ErrNone);
        put(Utf8Cont | {2'b00, cp[5:0]}, KindByte, ErrNone);
      end
    endfunction

    // decode one accepted input word
    function void take_input(logic cmd, logic [7:0] c);
      int v;
      run_words.delete();
      if (cmd == CmdEnd) begin
        case (scan)
          ScanBody:   fail(ErrUnterminated);
          ScanEscape: fail(ErrEscapeAtEnd);
          ScanHex:    fail(ErrHexShort);
          default:    fail(ErrExpectQuote);
        endcase
      end else begin
        case (scan)
          ScanSeek: begin
            if (c == ChQuote) begin
              scan = ScanBody;
            end else if (c != ChSpace && c != ChTab && c != ChCr && c != ChLf) begin
              fail(ErrExpectQuote);
            end
          end
          ScanBody: begin
            if (c == ChQuote) begin
              clear_scan();
              put(8'h00, KindDone, ErrNone);
            end else if (c == ChBslash) begin
              scan = ScanEscape;
            end else begin
              put(c, KindByte, ErrNone);
            end
          end
          ScanEscape: begin
            scan = ScanBody;
            case (c)
              ChQuote, ChBslash, ChSlash: put(c, KindByte, ErrNone);
              ChB: put(ChBs, KindByte, ErrNone);
              ChF: put(ChFf, KindByte, ErrNone);
              ChN: put(ChLf, KindByte, ErrNone);
              ChR: put(ChCr, KindByte, ErrNone);
              ChT: put(ChTab, KindByte, ErrNone);
              ChU: begin
                scan       = ScanHex;
                digits     = 2'd0;
                code_point = 16'h0000;
                bad_digit  = 1'b0;
              end
              default: fail(ErrBadEscape);
            endcase
          end
          default: begin
            // a non-hex byte counts as zero, the error waits for the fourth digit
            v = hex_nibble(c);
            if (v < 0) begin
              bad_digit = 1'b1;
              v = 0;
            end
            code_point = {code_point[11:0], 4'(v)};
            if (digits != 2'd3) begin
              digits = digits + 2'd1;
            end else if (bad_digit) begin
              fail(ErrBadHex);
            end else begin
              put_utf8(code_point);
              scan       = ScanBody;
              digits     = 2'd0;
              code_point = 16'h0000;
            end
          end
        endcase
      end
      if (run_words.size() > 0) begin
        run_words[$].last = 1'b1;
        pending_words = {pending_words, run_words};
      end
    endfunction

    // compare one output word with the oldest queued word
    function void check_result(result_t got);
      result_t want;
      if (got.kind == KindDone) strings_closed++;
      if (got.kind == KindErr) errors_reported++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: data %02h err %0d kind %0d last %0b",
                   got.data, got.err, got.kind, got.last);
        return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (got.data !== want.data || got.err !== want.err ||
          got.kind !== want.kind || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch data/err/kind/last: exp %02h/%0d/%0d/%0b, got %02h/%0d/%0d/%0b",
                   want.data, want.err, want.kind, want.last,
                   got.data, got.err, got.kind, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] out_byte, [10:8] error_code, zero pad
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;

  unescape_board board = new();
  int            words_sent = 0;
  int            burst_left = 0;

  json_string_unescaper_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RunLimit);
    $display("tb_json_string_unescaper_core: done, errors");
    $finish;
  end

  // receiver: check accepted words, stall in changing patterns
  initial begin
    int      mode;
    int      mode_left;
    int      cyc;
    result_t got;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.data = m_axis_tdata[7:0];
        got.err  = m_axis_tdata[10:8];
        got.kind = m_axis_tuser;
        got.last = m_axis_tlast;
        board.check_result(got);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cyc++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 99) < 70);
        2:       m_axis_tready <= ((cyc % 4) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one input word, held until taken; bursts end in a random gap
  task automatic send_word(input logic cmd, input logic [7:0] b, input bit counted = 1'b1);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_input(cmd, b);
    if (counted) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the input until every queued word has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return ChDigit0 + 8'(n);
    return ($urandom_range(0, 1) ? ChHexLow : ChHexUp) + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      default: return ChLf;
    endcase
  endfunction

  // \u escape with a code point of random utf-8 length; may be broken
  // returns 1 when the string has been cut short or given a bad digit
  task automatic send_unicode(output bit broken);
    logic [15:0] cp;
    logic [7:0]  b;
    int          bad_at;
    int          cut_at;
    broken = 1'b0;
    case ($urandom_range(0, 2))
      0:       cp = 16'($urandom_range(0, 'h7f));
      1:       cp = 16'($urandom_range('h80, 'h7ff));
      default: cp = 16'($urandom_range('h800, 'hffff));
    endcase
    bad_at = ($urandom_range(0, 99) < 12) ? $urandom_range(0, 3) : -1;
    cut_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 3) : -1;
    send_word(CmdData, ChBslash);
    send_word(CmdData, ChU);
    for (int i = 0; i < 4; i++) begin
      if (i == cut_at) begin
        send_word(CmdEnd, 8'($urandom_range(0, 255)));
        broken = 1'b1;
        return;
      end
      if (i == bad_at) begin
        do b = 8'($urandom_range(0, 255)); while (unescape_board::hex_nibble(b) >= 0);
      end else begin
        b = hex_char(cp[15 - 4 * i -: 4]);
      end
      send_word(CmdData, b);
    end
    broken = (bad_at >= 0);
  endtask

  // one string literal with random content, mostly well formed
  task automatic send_random_string();
    logic [7:0] escapes[8];
    logic [7:0] b;
    bit         broken;
    int         n_el;
    int         sel;
    escapes = '{ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT};
    repeat ($urandom_range(0, 2)) send_word(CmdData, pick_space(), 1'b0);
    send_word(CmdData, ChQuote);
    n_el = $urandom_range(0, 6);
    for (int i = 0; i < n_el; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 9) begin
        do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBslash);
        send_word(CmdData, b);
      end else if (sel < 13) begin
        send_word(CmdData, ChBslash);
        send_word(CmdData, escapes[$urandom_range(0, 7)]);
      end else if (sel < 18) begin
        send_unicode(broken);
        if (broken) return;
      end else if (sel == 18) begin
        // unknown escape letter
        do b = 8'($urandom_range(0, 255));
        while (b inside {ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT, ChU});
        send_word(CmdData, ChBslash);
        send_word(CmdData, b);
        return;
      end else begin
        // input ends right after a backslash
        send_word(CmdData, ChBslash);
        send_word(CmdEnd, 8'($urandom_range(0, 255)));
        return;
      end
    end
    if ($urandom_range(0, 99) < 88) send_word(CmdData, ChQuote);
    else send_word(CmdEnd, 8'($urandom_range(0, 255)));
  endtask

  // stimulus
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= CmdData;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 30);

    // directed: extremes, escapes, three-byte code point, each error but bad hex
    send_word(CmdData, ChSpace);
    send_word(CmdData, ChQuote);
    send_word(CmdData, 8'h00);
    send_word(CmdData, 8'hff);
    send_word(CmdData, ChBslash);
    send_word(CmdData, ChN);
    send_word(CmdData, ChBslash);
    send_word(CmdData, ChU);
    send_word(CmdData, ChHexLow + 8'd5);
    send_word(CmdData, ChHexUp + 8'd5);
    send_word(CmdData, ChHexLow + 8'd5);
    send_word(CmdData, ChHexUp + 8'd5);
    send_word(CmdData, ChQuote);
    // end mark right after a finished string
    send_word(CmdEnd, 8'h00);
    // stray byte while seeking
    send_word(CmdData, 8'h78);
    send_word(CmdData, ChTab);
    send_word(CmdData, ChQuote);
    send_word(CmdData, ChBslash);
    send_word(CmdData, 8'h71);
    send_word(CmdData, ChQuote);
    send_word(CmdData, ChBslash);
    send_word(CmdEnd, 8'hff);
    send_word(CmdData, ChQuote);
    send_word(CmdEnd, 8'h00);
    // end among hex digits after a bad digit: short hex wins
    send_word(CmdData, ChQuote);
    send_word(CmdData, ChBslash);
    send_word(CmdData, ChU);
    send_word(CmdData, 8'h67);
    send_word(CmdEnd, 8'h00);
    drain_results();

    // random: well-formed strings mostly, broken ones and noise besides
    while (words_sent < NumRandomWords) begin
      if ($urandom_range(0, 9) < 8) begin
        send_random_string();
      end else begin
        repeat ($urandom_range(1, 3))
          send_word(($urandom_range(0, 3) == 0) ? CmdEnd : CmdData,
                    8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    // wait for the last words, then wait on for strays
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (board.pending_words.size() != 0);
    repeat (FlushCycles) @(posedge clk_i);
    if (board.pending_words.size() != 0) begin
      board.mismatches++;
      $display("%0d expected words never came out", board.pending_words.size());
    end

    $display("covered %0d input words and %0d checked result words",
             words_sent, board.words_checked);
    $display("strings closed: %0d, error reports: %0d, mismatches: %0d",
             board.strings_closed, board.errors_reported, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb_json_string_unescaper_core: done, clean");
    end else begin
      $display("tb_json_string_unescaper_core: done, errors");
    end
    $finish;
  end

endmodule
